[hw/rtl/ntt_pkg.sv]
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared types and constants of the neighbor trust table.
// ----------------------------------------------------------------------------
`default_nettype none

package ntt_pkg;

  localparam int NODES_DEF           = 64;
  localparam int COUNT_WIDTH_DEF     = 16;
  localparam int TRUST_FRAC_BITS_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int NODE_W   = $clog2(NODES_DEF);
  localparam int TRUST_W  = TRUST_FRAC_BITS_DEF + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [TRUST_W-1:0] TRUST_RESET = TRUST_W'(32768);

  typedef enum logic [MODE_W-1:0] {
    MODE_ACK    = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_TRUST = 1'd0,
    REG_THRESHOLD  = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT,
    ST_LDIV,
    ST_RRD,
    ST_RCHK,
    ST_RDIV,
    ST_MUL,
    ST_ACC,
    ST_GST,
    ST_GDIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/ntt_if.sv]
// ----------------------------------------------------------------------------
// ntt_in_if / ntt_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntt_in_if;
  logic                        valid;
  logic                        ready;
  logic [ntt_pkg::MODE_W-1:0]  mode;
  logic [ntt_pkg::NODE_W-1:0]  node;
  logic [ntt_pkg::NODE_W-1:0]  reporter;
  logic                        legit;
  logic [ntt_pkg::TRUST_W-1:0] reported_trust;

  modport source (output valid, mode, node, reporter, legit, reported_trust, input ready);
  modport sink   (input valid, mode, node, reporter, legit, reported_trust, output ready);
endinterface

interface ntt_out_if;
  logic                        valid;
  logic                        ready;
  logic [ntt_pkg::TRUST_W-1:0] local_trust;
  logic [ntt_pkg::TRUST_W-1:0] global_trust;
  logic                        suspected;
  logic                        has_sent;

  modport source (output valid, local_trust, global_trust, suspected, has_sent, input ready);
  modport sink   (input valid, local_trust, global_trust, suspected, has_sent, output ready);
endinterface

`default_nettype wire

[hw/rtl/ntt_div.sv]
// ----------------------------------------------------------------------------
// ntt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_div #(
  parameter int DVW = 32,
  parameter int DSW = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [DSW-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [DVW-1:0]      quotient
);

  localparam int STW = $clog2(DVW + 1);

  logic [DSW-1:0] rem_r, rem_nxt;
  logic [DSW-1:0] dsr_r;
  logic [DVW-1:0] dvd_r, dvd_nxt;
  logic [STW-1:0] step_r;
  logic           busy_r, done_r;
  logic [DSW:0]   shifted;
  logic           ge;

  always_comb begin
    shifted = {rem_r, dvd_r[DVW-1]};
    ge      = shifted >= {1'b0, dsr_r};
    rem_nxt = ge ? DSW'(shifted - {1'b0, dsr_r}) : DSW'(shifted);
    dvd_nxt = {dvd_r[DVW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STW'(1);
        if (step_r == STW'(DVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

[hw/rtl/neighbor_trust_table_unit.sv]
// ----------------------------------------------------------------------------
// neighbor_trust_table_unit
// Per-neighbor ack counters, reported-trust table and trust aggregation.
// ----------------------------------------------------------------------------
// Report item: written in the cycle it is accepted if in range, no result.
// Ack/query item: counters read (bumped for an ack), local trust divided, then each
// valid report weighted and summed, then global trust divided; one shared divider.
// Serial divider width DVW = max(COUNT_WIDTH+TRUST_FRAC_BITS, ...), 32 at defaults.
// One item at a time; the next is accepted as soon as its result is registered.
// After reset a clearing pass sweeps both memories.
`default_nettype none

module neighbor_trust_table_unit #(
  parameter int COUNT_WIDTH     = ntt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ntt_in_if.sink                             in_if,
  ntt_out_if.source                          out_if,
  input  wire logic                          cfg_we,
  input  wire logic [ntt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ntt_pkg::TRUST_W-1:0]   cfg_wdata
);

  import ntt_pkg::*;

  localparam int NODES           = NODES_DEF;
  localparam int TRUST_FRAC_BITS = TRUST_FRAC_BITS_DEF;
  localparam int F     = TRUST_FRAC_BITS;
  localparam int TW    = F + 1;
  localparam int CW    = COUNT_WIDTH;
  localparam int NW    = $clog2(NODES);
  localparam int ENT   = NODES * NODES;
  localparam int RIW   = $clog2(ENT);
  localparam int CNTW  = $clog2(NODES + 2);
  localparam int ACCW  = 2 * F + 2 + CNTW;
  localparam int LDW   = CW + F;
  localparam int GDW   = ACCW - F;
  localparam int DVW   = (LDW > GDW) ? LDW : GDW;
  localparam int DSW   = (CW > CNTW) ? CW : CNTW;
  localparam logic [TW-1:0] ONE_Q = {1'b1, {F{1'b0}}};
  localparam logic [CW-1:0] CMAX  = '1;

  state_t state_r, state_nxt;

  logic [TRUST_W-1:0] init_r, thr_r;
  logic [RIW-1:0]     clr_r, clr_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [NW-1:0]      node_r, node_nxt;
  logic               inr_r, inr_nxt;
  logic               legit_r, legit_nxt;
  logic [NW-1:0]      r_r, r_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [TW-1:0]      loc_r, loc_nxt;
  logic [TW-1:0]      glob_r, glob_nxt;
  logic [TW-1:0]      locr_r, locr_nxt;
  logic [TW-1:0]      val_r, val_nxt;
  logic [2*TW-1:0]    prod_r, prod_nxt;
  logic [ACCW-1:0]    acc_r, acc_nxt;
  logic               sent_r, sent_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TRUST_W-1:0] out_loc_r, out_loc_nxt, out_glob_r, out_glob_nxt;
  logic               out_sus_r, out_sus_nxt, out_has_r, out_has_nxt;

  logic [2*CW-1:0] cnt_mem [NODES];
  logic [2*CW-1:0] cnt_rd_r;
  logic            cnt_we;
  logic [NW-1:0]   cnt_wa, cnt_ra;
  logic [2*CW-1:0] cnt_wd;

  logic [TW:0]     rep_mem [ENT];
  logic [TW:0]     rep_rd_r;
  logic            rep_we;
  logic [RIW-1:0]  rep_wa, rep_ra;
  logic [TW:0]     rep_wd;

  logic            div_start, div_busy, div_done;
  logic [DVW-1:0]  div_dvd, div_q;
  logic [DSW-1:0]  div_dsr;

  logic            accept, in_range, rep_range, last_r;
  logic [TW-1:0]   init_lim, rep_lim;
  logic [CW-1:0]   rd_sent, rd_legit, sent_new, legit_new, n_sent, n_legit;

  assign accept    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_range  = 32'(in_if.node) < 32'(NODES);
  assign rep_range = in_range && (32'(in_if.reporter) < 32'(NODES));
  assign last_r    = (r_r == NW'(NODES - 1));
  assign init_lim  = (32'(init_r) > 32'(ONE_Q)) ? ONE_Q : TW'(init_r);
  assign rep_lim   = (32'(in_if.reported_trust) > 32'(ONE_Q)) ? ONE_Q
                                                             : TW'(in_if.reported_trust);
  assign rd_sent   = cnt_rd_r[2*CW-1:CW];
  assign rd_legit  = cnt_rd_r[CW-1:0];
  assign sent_new  = (rd_sent != CMAX) ? rd_sent + CW'(1) : rd_sent;
  assign legit_new = (legit_r && (rd_legit < sent_new)) ? rd_legit + CW'(1) : rd_legit;
  assign n_sent    = (mode_r == MODE_ACK) ? sent_new : rd_sent;
  assign n_legit   = (mode_r == MODE_ACK) ? legit_new : rd_legit;

  ntt_div #(.DVW(DVW), .DSW(DSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == RIW'(ENT - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && (in_if.mode == MODE_ACK || in_if.mode == MODE_QUERY)) begin
          state_nxt = ST_CNT;
        end
      end
      ST_CNT: begin
        if (!inr_r) state_nxt = ST_DONE;
        else if (n_sent != '0) state_nxt = ST_LDIV;
        else state_nxt = ST_RRD;
      end
      ST_LDIV: if (div_done) state_nxt = ST_RRD;
      ST_RRD:  state_nxt = ST_RCHK;
      ST_RCHK: begin
        if (!rep_rd_r[TW]) state_nxt = last_r ? ST_GST : ST_RRD;
        else if (rd_sent != '0) state_nxt = ST_RDIV;
        else state_nxt = ST_MUL;
      end
      ST_RDIV: if (div_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_r ? ST_GST : ST_RRD;
      ST_GST:  state_nxt = ST_GDIV;
      ST_GDIV: if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt   = clr_r;
    mode_nxt  = mode_r;
    node_nxt  = node_r;
    inr_nxt   = inr_r;
    legit_nxt = legit_r;
    r_nxt     = r_r;
    cnt_nxt   = cnt_r;
    loc_nxt   = loc_r;
    glob_nxt  = glob_r;
    locr_nxt  = locr_r;
    val_nxt   = val_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    sent_nxt  = sent_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_loc_nxt   = out_loc_r;
    out_glob_nxt  = out_glob_r;
    out_sus_nxt   = out_sus_r;
    out_has_nxt   = out_has_r;
    cnt_we = 1'b0;
    cnt_wa = node_r;
    cnt_wd = {n_sent, n_legit};
    cnt_ra = (state_r == ST_IDLE) ? NW'(in_if.node) : r_r;
    rep_we = 1'b0;
    rep_wa = RIW'(in_if.node) * RIW'(NODES) + RIW'(in_if.reporter);
    rep_wd = {1'b1, rep_lim};
    rep_ra = RIW'(node_r) * RIW'(NODES) + RIW'(r_r);
    div_start = 1'b0;
    div_dvd   = DVW'(n_legit) << F;
    div_dsr   = DSW'(n_sent);
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + RIW'(1);
        rep_we  = 1'b1;
        rep_wa  = clr_r;
        rep_wd  = '0;
        if (32'(clr_r) < 32'(NODES)) begin
          cnt_we = 1'b1;
          cnt_wa = NW'(clr_r);
          cnt_wd = '0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_nxt  = in_if.mode;
          node_nxt  = NW'(in_if.node);
          inr_nxt   = in_range;
          legit_nxt = in_if.legit;
          if (in_if.mode == MODE_REPORT && rep_range) rep_we = 1'b1;
        end
      end
      ST_CNT: begin
        cnt_we   = inr_r && (mode_r == MODE_ACK);
        sent_nxt = inr_r && (n_sent != '0);
        loc_nxt  = init_lim;
        glob_nxt = init_lim;
        acc_nxt  = ACCW'(init_lim) << F;
        cnt_nxt  = '0;
        r_nxt    = '0;
        div_start = inr_r && (n_sent != '0);
      end
      ST_LDIV: begin
        if (div_done) begin
          loc_nxt = TW'(div_q);
          acc_nxt = ACCW'(TW'(div_q)) << F;
        end
      end
      ST_RCHK: begin
        div_dvd = DVW'(rd_legit) << F;
        div_dsr = DSW'(rd_sent);
        if (rep_rd_r[TW]) begin
          cnt_nxt  = cnt_r + CNTW'(1);
          val_nxt  = rep_rd_r[TW-1:0];
          locr_nxt = init_lim;
          div_start = (rd_sent != '0);
        end else if (!last_r) begin
          r_nxt = r_r + NW'(1);
        end
      end
      ST_RDIV: if (div_done) locr_nxt = TW'(div_q);
      ST_MUL:  prod_nxt = locr_r * val_r;
      ST_ACC: begin
        acc_nxt = acc_r + ACCW'(prod_r);
        if (!last_r) r_nxt = r_r + NW'(1);
      end
      ST_GST: begin
        div_start = 1'b1;
        div_dvd   = DVW'(acc_r >> F);
        div_dsr   = DSW'(cnt_r + CNTW'(1));
      end
      ST_GDIV: if (div_done) glob_nxt = TW'(div_q);
      ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_loc_nxt   = TRUST_W'(loc_r);
          out_glob_nxt  = TRUST_W'(glob_r);
          out_sus_nxt   = 32'(glob_r) < 32'(thr_r);
          out_has_nxt   = sent_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      init_r      <= TRUST_RESET;
      thr_r       <= TRUST_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_INIT_TRUST: init_r <= cfg_wdata;
          REG_THRESHOLD:  thr_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    node_r     <= node_nxt;
    inr_r      <= inr_nxt;
    legit_r    <= legit_nxt;
    r_r        <= r_nxt;
    cnt_r      <= cnt_nxt;
    loc_r      <= loc_nxt;
    glob_r     <= glob_nxt;
    locr_r     <= locr_nxt;
    val_r      <= val_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    sent_r     <= sent_nxt;
    out_loc_r  <= out_loc_nxt;
    out_glob_r <= out_glob_nxt;
    out_sus_r  <= out_sus_nxt;
    out_has_r  <= out_has_nxt;
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (rep_we) rep_mem[rep_wa] <= rep_wd;
    rep_rd_r <= rep_mem[rep_ra];
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.local_trust  = out_loc_r;
  assign out_if.global_trust = out_glob_r;
  assign out_if.suspected    = out_sus_r;
  assign out_if.has_sent     = out_has_r;

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside completion");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC || state_r == ST_GST) |-> (32'(cnt_r) <= 32'(NODES)))
    else $error("report count overflow");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> !(accept && $past(state_r == ST_CLEAR) && state_r == ST_CLEAR))
    else $error("item accepted during clearing pass");

endmodule

`default_nettype wire
